// ----- design/wavp_pkg.sv -----
// Shared types and constants for the RIFF/WAVE PCM16 parser.
package wavp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [3:0]  HEADER_LEN  = 4'd12;
  localparam logic [4:0]  BODY_POS_SAT = 5'd16;

  localparam logic [15:0] FMT_PCM    = 16'd1;
  localparam logic [15:0] CHAN_MONO  = 16'd1;
  localparam logic [15:0] BITS_PCM16 = 16'd16;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_CHDR   = 2'd1,
    PH_BODY   = 2'd2,
    PH_PAD    = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_TOO_SMALL  = 4'd1,
    ST_BAD_MAGIC  = 4'd2,
    ST_BAD_SIZE   = 4'd3,
    ST_BAD_FMT    = 4'd4,
    ST_NOT_PCM    = 4'd5,
    ST_NOT_MONO   = 4'd6,
    ST_NOT_16BIT  = 4'd7,
    ST_NO_DATA    = 4'd8,
    ST_ODD_DATA   = 4'd9
  } status_t;

  // Everything one input byte produces: an optional sample and an optional status
  typedef struct packed {
    logic               has_sample;
    logic               has_status;
    logic signed [15:0] sample;
    logic [7:0]         chunk_number;
    status_t            status;
    logic [31:0]        rate;
    logic [30:0]        sample_count;
  } res_entry_t;

  function automatic logic [7:0] byte_of(input logic [31:0] word, input logic [1:0] idx);
    byte_of = word[idx*8 +: 8];
  endfunction

endpackage

// ----- design/riff_wave_pcm16_parser.sv -----
// Top level of the RIFF/WAVE PCM16 mono stream parser.
//
// Input: one file byte per transfer on s_axis, s_axis_tlast on the file's final byte.
// Output on m_axis: a sample result (tuser 0) for each byte pair of a data chunk,
// and a status result (tuser 1) after the final byte; tlast marks the last result
// caused by one input byte. Samples are sent before the file is validated; keep
// those of the last data chunk when the status is ok.
// Throughput: one byte per cycle while the result queue has room. A final byte
// in a data chunk yields two transfers, a sample and then a status.
// The results of an accepted byte are written into the queue at the accepting edge.
// The parser state updates at the accepting edge; results wait in a four-entry
// queue, so s_axis_tready drops only when that queue is full (receiver stalled).
// Reset (rst, synchronous) empties the queue and returns the parser to the
// header check; after the final byte of a file it returns there on its own.
module riff_wave_pcm16_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sample[15:0], chunk_number[23:16], status_code[27:24], rate_out[59:28],
  // sample_count[90:60], zero fill [95:91]
  output logic [95:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // run_last
);

  logic                 acc;
  logic                 push;
  wavp_pkg::res_entry_t entry;

  assign acc = s_axis_tvalid && s_axis_tready;

  wavp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .byte_in (s_axis_tdata),
    .eof     (s_axis_tlast),
    .push    (push),
    .entry   (entry)
  );

  wavp_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .entry         (entry),
    .ready         (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- design/wavp_parse.sv -----
// Header check, chunk walk and fmt/data decode, one byte per cycle while acc is high.
module wavp_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  acc,
  input  logic [7:0]            byte_in,
  input  logic                  eof,
  output logic                  push,
  output wavp_pkg::res_entry_t  entry
);

  wavp_pkg::phase_t  phase, phase_next;
  logic [3:0]        position, position_next;
  logic              header_bad, header_bad_next;
  logic [31:0]       chunk_tag, chunk_tag_next;
  logic [31:0]       chunk_length, chunk_length_next;
  logic [31:0]       body_remaining, body_remaining_next;
  logic [4:0]        body_pos, body_pos_next;
  logic              body_odd, body_odd_next;
  logic [63:0]       fmt_scratch, fmt_scratch_next;
  logic [15:0]       fmt_bits, fmt_bits_next;
  logic [15:0]       format_code, format_code_next;
  logic [15:0]       channel_count, channel_count_next;
  logic [31:0]       rate_reg, rate_reg_next;
  logic [15:0]       sample_bits, sample_bits_next;
  logic [31:0]       data_length, data_length_next;
  logic [7:0]        data_chunk_seen, data_chunk_seen_next;
  logic [7:0]        low_byte, low_byte_next;
  wavp_pkg::status_t first_error, first_error_next;

  logic              fin;
  logic [31:0]       fin_len;
  logic [31:0]       len_full;
  wavp_pkg::status_t status;

  always_comb begin
    phase_next           = phase;
    position_next        = position;
    header_bad_next      = header_bad;
    chunk_tag_next       = chunk_tag;
    chunk_length_next    = chunk_length;
    body_remaining_next  = body_remaining;
    body_pos_next        = body_pos;
    body_odd_next        = body_odd;
    fmt_scratch_next     = fmt_scratch;
    fmt_bits_next        = fmt_bits;
    format_code_next     = format_code;
    channel_count_next   = channel_count;
    rate_reg_next        = rate_reg;
    sample_bits_next     = sample_bits;
    data_length_next     = data_length;
    data_chunk_seen_next = data_chunk_seen;
    low_byte_next        = low_byte;
    first_error_next     = first_error;
    fin                  = 1'b0;
    fin_len              = chunk_length;
    len_full             = {byte_in, chunk_length[23:0]};

    if (acc) begin
      unique case (phase)
        wavp_pkg::PH_HEADER: begin
          if (position < 4'd4) begin
            if (byte_in != wavp_pkg::byte_of(wavp_pkg::TAG_RIFF, position[1:0]))
              header_bad_next = 1'b1;
          end else if (position >= 4'd8) begin
            if (byte_in != wavp_pkg::byte_of(wavp_pkg::TAG_WAVE, position[1:0]))
              header_bad_next = 1'b1;
          end
          if (position == wavp_pkg::HEADER_LEN - 4'd1) begin
            phase_next    = wavp_pkg::PH_CHDR;
            position_next = '0;
          end else begin
            position_next = position + 4'd1;
          end
        end
        wavp_pkg::PH_CHDR: begin
          if (!position[2]) begin
            if (position[1:0] == 2'd0) chunk_tag_next = {24'd0, byte_in};
            else chunk_tag_next[position[1:0]*8 +: 8] = byte_in;
          end else begin
            if (position[1:0] == 2'd0) chunk_length_next = {24'd0, byte_in};
            else chunk_length_next[position[1:0]*8 +: 8] = byte_in;
          end
          if (position[2:0] == 3'd7) begin
            if (chunk_tag == wavp_pkg::TAG_DATA && data_chunk_seen != 8'hFF)
              data_chunk_seen_next = data_chunk_seen + 8'd1;
            if (chunk_tag == wavp_pkg::TAG_FMT) begin
              fmt_scratch_next = '0;
              fmt_bits_next    = '0;
            end
            body_remaining_next = len_full;
            body_pos_next       = '0;
            body_odd_next       = 1'b0;
            position_next       = '0;
            if (len_full == 32'd0) begin
              fin     = 1'b1;
              fin_len = len_full;
            end else begin
              phase_next = wavp_pkg::PH_BODY;
            end
          end else begin
            position_next = position + 4'd1;
          end
        end
        wavp_pkg::PH_BODY: begin
          if (chunk_tag == wavp_pkg::TAG_FMT) begin
            if (body_pos < 5'd8) fmt_scratch_next[body_pos[2:0]*8 +: 8] = byte_in;
            else if (body_pos == 5'd14) fmt_bits_next[7:0] = byte_in;
            else if (body_pos == 5'd15) fmt_bits_next[15:8] = byte_in;
          end else if (chunk_tag == wavp_pkg::TAG_DATA) begin
            if (!body_odd) low_byte_next = byte_in;
          end
          body_odd_next       = !body_odd;
          body_pos_next       = (body_pos == wavp_pkg::BODY_POS_SAT) ? body_pos
                                                                      : body_pos + 5'd1;
          body_remaining_next = body_remaining - 32'd1;
          if (body_remaining == 32'd1) fin = 1'b1;
        end
        wavp_pkg::PH_PAD: begin
          phase_next    = wavp_pkg::PH_CHDR;
          position_next = '0;
        end
        default: ;
      endcase

      if (fin) begin
        if (chunk_tag == wavp_pkg::TAG_FMT) begin
          if (fin_len < wavp_pkg::FMT_MIN_LEN) begin
            if (first_error == wavp_pkg::ST_OK) first_error_next = wavp_pkg::ST_BAD_FMT;
          end else begin
            format_code_next   = fmt_scratch_next[15:0];
            channel_count_next = fmt_scratch_next[31:16];
            rate_reg_next      = fmt_scratch_next[63:32];
            sample_bits_next   = fmt_bits_next;
          end
        end else if (chunk_tag == wavp_pkg::TAG_DATA) begin
          data_length_next = fin_len;
        end
        phase_next    = fin_len[0] ? wavp_pkg::PH_PAD : wavp_pkg::PH_CHDR;
        position_next = '0;
      end
    end
  end

  // Final status, first match wins
  always_comb begin
    priority if (phase_next == wavp_pkg::PH_HEADER)   status = wavp_pkg::ST_TOO_SMALL;
    else if (header_bad_next)                          status = wavp_pkg::ST_BAD_MAGIC;
    else if (first_error_next != wavp_pkg::ST_OK)      status = first_error_next;
    else if (phase_next == wavp_pkg::PH_BODY)          status = wavp_pkg::ST_BAD_SIZE;
    else if (format_code_next != wavp_pkg::FMT_PCM)    status = wavp_pkg::ST_NOT_PCM;
    else if (channel_count_next != wavp_pkg::CHAN_MONO) status = wavp_pkg::ST_NOT_MONO;
    else if (sample_bits_next != wavp_pkg::BITS_PCM16) status = wavp_pkg::ST_NOT_16BIT;
    else if (data_length_next == 32'd0)                status = wavp_pkg::ST_NO_DATA;
    else if (data_length_next[0])                      status = wavp_pkg::ST_ODD_DATA;
    else                                               status = wavp_pkg::ST_OK;
  end

  always_comb begin
    entry.has_sample   = acc && phase == wavp_pkg::PH_BODY &&
                         chunk_tag == wavp_pkg::TAG_DATA && body_odd;
    entry.has_status   = acc && eof;
    entry.sample       = {byte_in, low_byte};
    entry.chunk_number = data_chunk_seen_next;
    entry.status       = status;
    entry.rate         = rate_reg_next;
    entry.sample_count = data_length_next[31:1];
    push               = entry.has_sample || entry.has_status;
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && eof)) begin
      phase           <= wavp_pkg::PH_HEADER;
      position        <= '0;
      header_bad      <= 1'b0;
      chunk_tag       <= '0;
      chunk_length    <= '0;
      body_remaining  <= '0;
      body_pos        <= '0;
      body_odd        <= 1'b0;
      fmt_scratch     <= '0;
      fmt_bits        <= '0;
      format_code     <= '0;
      channel_count   <= '0;
      rate_reg        <= '0;
      sample_bits     <= '0;
      data_length     <= '0;
      data_chunk_seen <= '0;
      low_byte        <= '0;
      first_error     <= wavp_pkg::ST_OK;
    end else begin
      phase           <= phase_next;
      position        <= position_next;
      header_bad      <= header_bad_next;
      chunk_tag       <= chunk_tag_next;
      chunk_length    <= chunk_length_next;
      body_remaining  <= body_remaining_next;
      body_pos        <= body_pos_next;
      body_odd        <= body_odd_next;
      fmt_scratch     <= fmt_scratch_next;
      fmt_bits        <= fmt_bits_next;
      format_code     <= format_code_next;
      channel_count   <= channel_count_next;
      rate_reg        <= rate_reg_next;
      sample_bits     <= sample_bits_next;
      data_length     <= data_length_next;
      data_chunk_seen <= data_chunk_seen_next;
      low_byte        <= low_byte_next;
      first_error     <= first_error_next;
    end
  end

endmodule

// ----- design/wavp_outq.sv -----
// Result queue: holds per-byte entries and sends sample then status as separate transfers.
module wavp_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wavp_pkg::res_entry_t entry,
  output logic                 ready,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [95:0]          m_axis_tdata,
  output logic [0:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  wavp_pkg::res_entry_t q [wavp_pkg::QDEPTH];
  logic [wavp_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [wavp_pkg::QAW:0]   count, count_next;
  logic                     half, half_next;
  wavp_pkg::res_entry_t     head;
  logic                     show_sample, xfer, pop;

  assign head        = q[rd_ptr];
  assign ready       = count != (wavp_pkg::QAW+1)'(wavp_pkg::QDEPTH);
  assign show_sample = head.has_sample && !half;
  assign m_axis_tvalid = count != '0;
  assign xfer        = m_axis_tvalid && m_axis_tready;
  assign pop         = xfer && (!show_sample || !head.has_status);

  always_comb begin
    if (show_sample) begin
      m_axis_tdata = {5'd0, 31'd0, 32'd0, wavp_pkg::ST_OK, head.chunk_number, head.sample};
      m_axis_tuser = 1'b0;
      m_axis_tlast = !head.has_status;
    end else begin
      m_axis_tdata = {5'd0, head.sample_count, head.rate, head.status,
                      head.chunk_number, 16'd0};
      m_axis_tuser = 1'b1;
      m_axis_tlast = 1'b1;
    end
  end

  always_comb begin
    count_next = count + (wavp_pkg::QAW+1)'(push) - (wavp_pkg::QAW+1)'(pop);
    half_next  = half;
    if (xfer) half_next = show_sample && head.has_status;
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      half   <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + wavp_pkg::QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + wavp_pkg::QAW'(1);
      count <= count_next;
      half  <= half_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (wavp_pkg::QAW+1)'(wavp_pkg::QDEPTH))
    else $error("result queue over-full");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> ready)
    else $error("entry written into a full queue");

  a_half_valid: assert property (@(posedge clk) disable iff (rst)
    half |-> (count != '0 && head.has_sample && head.has_status))
    else $error("sample sent flag without a two-result head");

  a_half_then_status: assert property (@(posedge clk) disable iff (rst)
    (xfer && show_sample && head.has_status) |=> (half && m_axis_tvalid))
    else $error("status transfer lost after its sample");

endmodule
